// File: rtl/bpe_pkg.sv
// Package for the buffer pool pin/evict block: slot table sizes, field widths,
// command and status codes, and the sequencer state type.
// No dependencies.
package bpe_pkg;

    // slot table geometry (slot and register fields are fixed width)
    localparam int SLOTS    = 16;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;
    localparam int FRAMES_W = 5;
    localparam int PAGE_W   = 32;
    localparam int ADDR_W   = 44;
    localparam int STS_W    = 3;

    // request commands
    localparam logic CMD_FIX   = 1'b0;
    localparam logic CMD_UNFIX = 1'b1;

    // result status codes
    localparam logic [STS_W-1:0] STS_HIT        = 3'd0;
    localparam logic [STS_W-1:0] STS_LOAD_FREE  = 3'd1;
    localparam logic [STS_W-1:0] STS_LOAD_EVICT = 3'd2;
    localparam logic [STS_W-1:0] STS_ALL_PINNED = 3'd3;
    localparam logic [STS_W-1:0] STS_RELEASED   = 3'd4;
    localparam logic [STS_W-1:0] STS_NOT_HELD   = 3'd5;
    localparam logic [STS_W-1:0] STS_PIN_SAT    = 3'd6;

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_DECIDE   = 6'b000100,
        ST_MUL_LOAD = 6'b001000,
        ST_MUL_WB   = 6'b010000,
        ST_RESP     = 6'b100000
    } bpe_state_t;

endpackage

// File: rtl/bpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/buffer_pool_pin_evict.sv
// Buffer pool slot manager top level: pin counts, release order, eviction.
// Depends on bpe_pkg and bpe_ram.

// One request is handled at a time and s_ready is high only while the block is
// idle. After acceptance a request walks the 16 slots through the page tag RAM
// (one slot per cycle, with registered read data), then decides and updates the
// slot table, then uses the shared address multiplier for the load address and
// then the writeback address, then presents the result and returns to idle.
// The result word is held on the m_ side until taken. frames_in_use is written
// through the cfg_ channel, which is always ready; writes belong between
// requests. No clearing pass is needed after reset.
module buffer_pool_pin_evict
    import bpe_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PINS   = 255
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FRAMES_W-1:0] cfg_frames_in_use,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [PAGE_W-1:0]   s_page_id,
    input  logic                s_mark_dirty,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STS_W-1:0]    m_status,
    output logic [SLOT_W-1:0]   m_slot,
    output logic [ADDR_W-1:0]   m_load_address,
    output logic                m_writeback_needed,
    output logic [ADDR_W-1:0]   m_writeback_address,
    output logic                m_still_pinned
);

    localparam int PIN_W  = $clog2(MAX_PINS + 1);
    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    localparam int PROD_W = PAGE_W + PB_W;

    localparam logic [PIN_W-1:0]    PIN_MAX = PIN_W'(MAX_PINS);
    localparam logic [PIN_W-1:0]    PIN_ONE = PIN_W'(1);
    localparam logic [PB_W-1:0]     PB_K    = PB_W'(PAGE_BYTES);
    localparam logic [CNT_W-1:0]    SCAN_END = CNT_W'(SLOTS);

    // sequencer
    bpe_state_t state_reg, state_next;

    // configuration
    logic [FRAMES_W-1:0] frames_reg;
    logic [CNT_W-1:0]    limit;

    // latched request
    logic              cmd_reg;
    logic [PAGE_W-1:0] page_reg;
    logic              mdirty_reg;

    // slot table (flops, read at the scan index; rank and order also across all slots)
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [PIN_W-1:0]  pin_reg   [SLOTS];
    logic [PIN_W-1:0]  pin_next  [SLOTS];
    logic [SLOTS-1:0]  dirty_reg, dirty_next;
    logic [SLOT_W-1:0] rank_reg  [SLOTS];
    logic [SLOT_W-1:0] rank_next [SLOTS];
    logic [SLOTS-1:0]  ord_reg, ord_next;

    // scan pipeline
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              comp_en_reg;
    logic [SLOT_W-1:0] comp_idx_reg;
    logic [PAGE_W-1:0] tag_rd_data;
    logic              tag_wr_en;
    logic [SLOT_W-1:0] tag_wr_addr;

    // scan results
    logic [CNT_W-1:0]  used_cnt_reg;
    logic [CNT_W-1:0]  ord_cnt_reg;
    logic              hit_found_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [PIN_W-1:0]  hit_pin_reg;
    logic              hit_ord_reg;
    logic [SLOT_W-1:0] hit_rank_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              vic_found_reg;
    logic [SLOT_W-1:0] vic_idx_reg;
    logic [SLOT_W-1:0] vic_rank_reg;
    logic [PAGE_W-1:0] vic_page_reg;
    logic              vic_dirty_reg;

    // current scanned entry
    logic cur_valid;
    logic cur_match;
    logic cur_victim;

    // decision and result
    logic [STS_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              pinned_reg, pinned_next;
    logic              wbn_reg, wbn_next;
    logic              load_en_reg, load_en_next;
    logic [ADDR_W-1:0] load_addr_reg;
    logic [ADDR_W-1:0] wb_addr_reg;

    // table update controls
    logic              rm_en;
    logic [SLOT_W-1:0] rm_idx;
    logic [SLOT_W-1:0] rm_rank;
    logic              push_en;
    logic [SLOT_W-1:0] push_rank;
    logic              tgt_en;
    logic [SLOT_W-1:0] tgt_idx;

    // shared address multiplier
    logic [PAGE_W-1:0] mul_op;
    logic [PROD_W-1:0] mul_prod;
    logic [ADDR_W-1:0] mul_addr;

    // handshakes
    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_RESP);

    // register clamp: 0 acts as 1, above the slot count acts as the slot count
    always_comb begin
        if (frames_reg == '0) begin
            limit = CNT_W'(1);
        end else if (CNT_W'(frames_reg) > SCAN_END) begin
            limit = SCAN_END;
        end else begin
            limit = CNT_W'(frames_reg);
        end
    end

    // page tag store
    bpe_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (tag_wr_addr),
        .wr_data (page_reg),
        .rd_addr (scan_idx_reg[SLOT_W-1:0]),
        .rd_data (tag_rd_data)
    );

    assign tag_wr_en   = tgt_en;
    assign tag_wr_addr = tgt_idx;

    // classify the entry whose tag just came out of the RAM
    assign cur_valid  = valid_reg[comp_idx_reg];
    assign cur_match  = cur_valid && (tag_rd_data == page_reg);
    assign cur_victim = cur_valid && (pin_reg[comp_idx_reg] == '0) && ord_reg[comp_idx_reg]
                        && (!vic_found_reg || (rank_reg[comp_idx_reg] < vic_rank_reg));

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == SCAN_END) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:   state_next = ST_MUL_LOAD;
            ST_MUL_LOAD: state_next = ST_MUL_WB;
            ST_MUL_WB:   state_next = ST_RESP;
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // decision and slot table update
    always_comb begin
        valid_next   = valid_reg;
        pin_next     = pin_reg;
        dirty_next   = dirty_reg;
        rank_next    = rank_reg;
        ord_next     = ord_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        pinned_next  = pinned_reg;
        wbn_next     = wbn_reg;
        load_en_next = load_en_reg;
        rm_en        = 1'b0;
        rm_idx       = hit_idx_reg;
        rm_rank      = hit_rank_reg;
        push_en      = 1'b0;
        push_rank    = hit_ord_reg ? SLOT_W'(ord_cnt_reg - CNT_W'(1)) : SLOT_W'(ord_cnt_reg);
        tgt_en       = 1'b0;
        tgt_idx      = free_idx_reg;

        if (state_reg == ST_DECIDE) begin
            status_next  = STS_HIT;
            slot_next    = '0;
            pinned_next  = 1'b0;
            wbn_next     = 1'b0;
            load_en_next = 1'b0;
            if (cmd_reg == CMD_FIX) begin
                if (hit_found_reg) begin
                    // hit: add a pin unless saturated
                    slot_next   = hit_idx_reg;
                    pinned_next = 1'b1;
                    if (hit_pin_reg >= PIN_MAX) begin
                        status_next = STS_PIN_SAT;
                    end else begin
                        pin_next[hit_idx_reg] = hit_pin_reg + PIN_ONE;
                    end
                end else if (used_cnt_reg < limit) begin
                    // miss with room: lowest free slot
                    status_next = STS_LOAD_FREE;
                    tgt_en      = 1'b1;
                    tgt_idx     = free_idx_reg;
                end else if (vic_found_reg) begin
                    // miss on a full pool: evict oldest released slot
                    status_next = STS_LOAD_EVICT;
                    wbn_next    = vic_dirty_reg;
                    rm_en       = 1'b1;
                    rm_idx      = vic_idx_reg;
                    rm_rank     = vic_rank_reg;
                    tgt_en      = 1'b1;
                    tgt_idx     = vic_idx_reg;
                end else begin
                    status_next = STS_ALL_PINNED;
                end
                if (tgt_en) begin
                    slot_next    = tgt_idx;
                    pinned_next  = 1'b1;
                    load_en_next = 1'b1;
                end
            end else begin
                if (!hit_found_reg) begin
                    status_next = STS_NOT_HELD;
                end else if (hit_pin_reg == '0) begin
                    status_next = STS_NOT_HELD;
                    slot_next   = hit_idx_reg;
                end else begin
                    // release one pin; last pin moves the slot to the newest end
                    status_next = STS_RELEASED;
                    slot_next   = hit_idx_reg;
                    pin_next[hit_idx_reg] = hit_pin_reg - PIN_ONE;
                    if (mdirty_reg) begin
                        dirty_next[hit_idx_reg] = 1'b1;
                    end
                    if (hit_pin_reg == PIN_ONE) begin
                        rm_en   = hit_ord_reg;
                        push_en = 1'b1;
                    end else begin
                        pinned_next = 1'b1;
                    end
                end
            end
        end

        // take a slot out of the release order, closing the gap
        if (rm_en) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (ord_reg[i] && (rank_reg[i] > rm_rank)) begin
                    rank_next[i] = rank_reg[i] - SLOT_W'(1);
                end
            end
            ord_next[rm_idx]  = 1'b0;
            rank_next[rm_idx] = '0;
        end

        // append the released slot at the newest end
        if (push_en) begin
            ord_next[hit_idx_reg]  = 1'b1;
            rank_next[hit_idx_reg] = push_rank;
        end

        // newly loaded slot
        if (tgt_en) begin
            valid_next[tgt_idx] = 1'b1;
            pin_next[tgt_idx]   = PIN_ONE;
            dirty_next[tgt_idx] = 1'b0;
        end
    end

    // shared multiplier: page number to byte address
    assign mul_op   = (state_reg == ST_MUL_LOAD) ? page_reg : vic_page_reg;
    assign mul_prod = PROD_W'(mul_op) * PROD_W'(PB_K);
    assign mul_addr = ADDR_W'(mul_prod);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            frames_reg <= FRAMES_W'(SLOTS);
            valid_reg  <= '0;
            dirty_reg  <= '0;
            ord_reg    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                pin_reg[i]  <= '0;
                rank_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                frames_reg <= cfg_frames_in_use;
            end
            valid_reg <= valid_next;
            pin_reg   <= pin_next;
            dirty_reg <= dirty_next;
            rank_reg  <= rank_next;
            ord_reg   <= ord_next;
        end
    end

    // request latch, scan walk and result words
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg        <= s_cmd;
            page_reg       <= s_page_id;
            mdirty_reg     <= s_mark_dirty;
            scan_idx_reg   <= '0;
            comp_en_reg    <= 1'b0;
            used_cnt_reg   <= '0;
            ord_cnt_reg    <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            vic_found_reg  <= 1'b0;
        end

        if (state_reg == ST_SCAN) begin
            // issue the next tag read, process the previous one
            comp_en_reg  <= (scan_idx_reg != SCAN_END);
            comp_idx_reg <= scan_idx_reg[SLOT_W-1:0];
            if (scan_idx_reg != SCAN_END) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (comp_en_reg) begin
                used_cnt_reg <= used_cnt_reg + CNT_W'(cur_valid);
                ord_cnt_reg  <= ord_cnt_reg + CNT_W'(ord_reg[comp_idx_reg]);
                if (cur_match && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= comp_idx_reg;
                    hit_pin_reg   <= pin_reg[comp_idx_reg];
                    hit_ord_reg   <= ord_reg[comp_idx_reg];
                    hit_rank_reg  <= rank_reg[comp_idx_reg];
                end
                if (!cur_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= comp_idx_reg;
                end
                if (cur_victim) begin
                    vic_found_reg <= 1'b1;
                    vic_idx_reg   <= comp_idx_reg;
                    vic_rank_reg  <= rank_reg[comp_idx_reg];
                    vic_page_reg  <= tag_rd_data;
                    vic_dirty_reg <= dirty_reg[comp_idx_reg];
                end
            end
        end

        status_reg  <= status_next;
        slot_reg    <= slot_next;
        pinned_reg  <= pinned_next;
        wbn_reg     <= wbn_next;
        load_en_reg <= load_en_next;

        if (state_reg == ST_MUL_LOAD) begin
            load_addr_reg <= load_en_reg ? mul_addr : '0;
        end
        if (state_reg == ST_MUL_WB) begin
            wb_addr_reg <= wbn_reg ? mul_addr : '0;
        end
    end

    // result word
    assign m_status            = status_reg;
    assign m_slot              = slot_reg;
    assign m_load_address      = load_addr_reg;
    assign m_writeback_needed  = wbn_reg;
    assign m_writeback_address = wb_addr_reg;
    assign m_still_pinned      = pinned_reg;

`ifndef NO_ASSERTIONS
    // a loaded page always leaves its slot valid and pinned
    a_load_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_LOAD &&
         (status_reg == STS_LOAD_FREE || status_reg == STS_LOAD_EVICT))
        |-> (valid_reg[slot_reg] && pin_reg[slot_reg] == PIN_ONE))
        else $error("loaded slot not valid with one pin");

    // only an eviction can ask for a writeback
    a_wb_only_on_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_writeback_needed) |-> (m_status == STS_LOAD_EVICT))
        else $error("writeback flagged without eviction");

    // loads leave the slot pinned
    a_load_pinned: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STS_LOAD_FREE || m_status == STS_LOAD_EVICT))
        |-> m_still_pinned)
        else $error("loaded page reported unpinned");

    // all-pinned result carries slot 0 and no pin
    a_all_pinned_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STS_ALL_PINNED)
        |-> (m_slot == '0 && !m_still_pinned && m_load_address == '0))
        else $error("all-pinned result fields wrong");

    // the scan finishes before any decision is taken
    a_scan_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> (!comp_en_reg && scan_idx_reg == SCAN_END))
        else $error("decision taken before scan completed");
`endif

endmodule
